// ===== rtl/utf8sd_pkg.sv =====
// utf8sd_pkg: field widths and clause-end punctuation table for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder and its testbench.
package utf8sd_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int COUT_W  = 16;
   localparam int N_MARKS = 12;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [COUT_W-1:0] cout_type;

   localparam cp_type CLAUSE_MARKS [N_MARKS] = '{
      21'h00_0021, 21'h00_002c, 21'h00_002e, 21'h00_003f,
      21'h00_2025, 21'h00_2026, 21'h00_3001, 21'h00_3002,
      21'h00_ff01, 21'h00_ff0c, 21'h00_ff0e, 21'h00_ff1f
   };

   function automatic logic is_mark(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < N_MARKS; i++) begin
         if (cp == CLAUSE_MARKS[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// utf8_stream_decoder: byte-serial UTF-8 decoder with clause-end flag and string length count.
// Depends on utf8sd_pkg (widths, punctuation table).
//
// Usage: raw bytes enter on the req_ channel, one per word. Decoded characters leave on
// the rsp_ channel, at most one per input byte. Lead bytes of multi-byte sequences and
// middle continuation bytes produce nothing; the character comes out with its last byte.
// A 0x00 lead returns an end-of-string word carrying the string length, then clears the
// count. Stray continuations and 0xf8-0xff leads come back as raw bytes with bad_lead set.
// Latency: a result is registered and is on rsp_ in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle while rsp_ready is high; the sequence state and the result register are both
// updated in the accept cycle, so bytes follow back to back with no gaps.
// Stall: the single result register holds its word while rsp_ready is low; req_ready
// follows rsp_ready then, so a new byte is still taken in the cycle the result drains.
// Reset (synchronous, active high) drops rsp_valid, closes any open sequence and
// clears the character count.
module utf8_stream_decoder #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  utf8sd_pkg::byte_type  req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utf8sd_pkg::cp_type    rsp_code_point,
   output logic                  rsp_is_clause_end,
   output logic                  rsp_bad_lead,
   output logic                  rsp_string_end,
   output utf8sd_pkg::cout_type  rsp_char_count
);
   import utf8sd_pkg::*;

   localparam int CNT_EXT_W = (COUNT_WIDTH > COUT_W) ? COUNT_WIDTH : COUT_W;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // sequence state
   logic [1:0] bytes_left_ff, bytes_left_in;
   cp_type     partial_ff, partial_in;
   count_type  count_ff, count_in;

   // result register
   logic     rsp_valid_ff;
   cp_type   rsp_cp_ff;
   logic     rsp_mark_ff, rsp_bad_ff, rsp_end_ff;
   cout_type rsp_count_ff;

   logic             accept;
   logic             emit;
   cp_type           cp_out;
   logic             mark_out, bad_out, end_out;
   count_type        count_out, count_inc;
   cp_type           pv_shift;
   logic [CNT_EXT_W-1:0] count_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign count_inc = (&count_ff) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign pv_shift  = {partial_ff[CP_W-7:0], req_in_byte[5:0]};

   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      count_in      = count_ff;
      emit          = 1'b0;
      cp_out        = '0;
      mark_out      = 1'b0;
      bad_out       = 1'b0;
      end_out       = 1'b0;
      count_out     = count_ff;
      if (bytes_left_ff != 2'd0) begin
         // continuation bytes are taken unchecked
         bytes_left_in = bytes_left_ff - 2'd1;
         if (bytes_left_ff == 2'd1) begin
            emit       = 1'b1;
            cp_out     = pv_shift;
            mark_out   = is_mark(pv_shift);
            count_in   = count_inc;
            count_out  = count_inc;
            partial_in = '0;
         end else begin
            partial_in = pv_shift;
         end
      end else begin
         unique case (req_in_byte) inside
            8'h00: begin
               emit      = 1'b1;
               end_out   = 1'b1;
               count_out = count_ff;
               count_in  = '0;
            end
            [8'h01:8'h7f]: begin
               emit      = 1'b1;
               cp_out    = CP_W'(req_in_byte);
               mark_out  = is_mark(CP_W'(req_in_byte));
               count_in  = count_inc;
               count_out = count_inc;
            end
            [8'h80:8'hbf], [8'hf8:8'hff]: begin
               emit      = 1'b1;
               cp_out    = CP_W'(req_in_byte);
               bad_out   = 1'b1;
               count_in  = count_inc;
               count_out = count_inc;
            end
            [8'hc0:8'hdf]: begin
               partial_in    = CP_W'(req_in_byte[4:0]);
               bytes_left_in = 2'd1;
            end
            [8'he0:8'hef]: begin
               partial_in    = CP_W'(req_in_byte[3:0]);
               bytes_left_in = 2'd2;
            end
            default: begin
               partial_in    = CP_W'(req_in_byte[2:0]);
               bytes_left_in = 2'd3;
            end
         endcase
      end
   end

   assign count_ext = CNT_EXT_W'(count_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         partial_ff    <= '0;
         count_ff      <= '0;
      end else if (accept) begin
         bytes_left_ff <= bytes_left_in;
         partial_ff    <= partial_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_cp_ff    <= cp_out;
         rsp_mark_ff  <= mark_out;
         rsp_bad_ff   <= bad_out;
         rsp_end_ff   <= end_out;
         rsp_count_ff <= count_ext[COUT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_point    = rsp_cp_ff;
   assign rsp_is_clause_end = rsp_mark_ff;
   assign rsp_bad_lead      = rsp_bad_ff;
   assign rsp_string_end    = rsp_end_ff;
   assign rsp_char_count    = rsp_count_ff;

   // a two-byte lead opens exactly one pending continuation
   a_two_byte_lead: assert property (@(posedge clock) disable iff (reset)
      accept && bytes_left_ff == 2'd0 && req_in_byte[7:5] == 3'b110
      |=> bytes_left_ff == 2'd1)
      else $error("two-byte lead did not set one pending byte");

   // terminator result carries no character and no error
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end
      |-> rsp_code_point == '0 && !rsp_bad_lead && !rsp_is_clause_end)
      else $error("end-of-string result has stray payload");

   // a bad lead is a raw byte and never a punctuation mark
   a_bad_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_lead
      |-> rsp_code_point[CP_W-1:BYTE_W] == '0 && !rsp_is_clause_end)
      else $error("bad lead result is not a raw byte");

   // terminator clears the count
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && bytes_left_ff == 2'd0 && req_in_byte == 8'h00
      |=> count_ff == '0)
      else $error("terminator did not clear the count");

endmodule

// ===== test/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for utf8_stream_decoder: byte stream in, decoded characters out.
// Depends on utf8sd_pkg (port types) and the utf8_stream_decoder RTL.
module utf8_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8sd_pkg::*;

   localparam int COUNT_W  = 16;
   localparam int WATCHDOG = 300;

   localparam byte_type TERMINATOR = 8'h00;
   localparam byte_type CONT_LO    = 8'h80;
   localparam byte_type LEAD2_LO   = 8'hc0;
   localparam byte_type LEAD3_LO   = 8'he0;
   localparam byte_type LEAD4_LO   = 8'hf0;
   localparam byte_type BAD_LO     = 8'hf8;

   localparam cp_type PUNCT_MARKS [12] = '{
      21'h0021, 21'h002c, 21'h002e, 21'h003f, 21'h2025, 21'h2026,
      21'h3001, 21'h3002, 21'hff01, 21'hff0c, 21'hff0e, 21'hff1f
   };

   typedef struct {
      byte_type value;
      bit       hold;   // wait for all outstanding characters before sending
   } feed_type;

   typedef struct {
      cp_type   cp;
      logic     mark;
      logic     bad;
      logic     fin;
      cout_type count;
   } decoded_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_in_byte = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   cp_type   rsp_code_point;
   logic     rsp_is_clause_end;
   logic     rsp_bad_lead;
   logic     rsp_string_end;
   cout_type rsp_char_count;

   feed_type    feed [$];
   decoded_type decoded_due [$];

   // decoder state mirror
   logic [1:0]         cont_left = '0;
   cp_type             gathered = '0;
   logic [COUNT_W-1:0] str_len = '0;

   int mismatches = 0;
   int stuck = 0;
   int bytes_queued = 0;
   int bytes_taken = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit jitter_on = 1'b1;
   bit hold_next = 1'b0;
   bit req_fire = 1'b0;

   utf8_stream_decoder #(.COUNT_WIDTH(COUNT_W)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_is_clause_end (rsp_is_clause_end),
      .rsp_bad_lead      (rsp_bad_lead),
      .rsp_string_end    (rsp_string_end),
      .rsp_char_count    (rsp_char_count)
   );

   always #5 clock = ~clock;

   function automatic logic is_clause_punct(input cp_type cp);
      logic hit;
      hit = 1'b0;
      foreach (PUNCT_MARKS[i]) begin
         if (PUNCT_MARKS[i] == cp) hit = 1'b1;
      end
      return hit;
   endfunction

   task automatic log_mismatch(input string msg);
      if (mismatches < 40) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic emit_word(input cp_type cp, input logic mark, input logic bad,
                            input logic fin);
      decoded_type w;
      w.cp    = cp;
      w.mark  = mark;
      w.bad   = bad;
      w.fin   = fin;
      w.count = cout_type'(str_len);
      decoded_due.push_back(w);
   endtask

   task automatic count_char();
      if (str_len != '1) str_len++;
   endtask

   task automatic decode_byte(input byte_type b);
      if (cont_left != 0) begin
         // continuation bytes are not checked, whatever their top bits
         gathered = {gathered[CP_W-7:0], b[5:0]};
         cont_left--;
         if (cont_left == 0) begin
            count_char();
            emit_word(gathered, is_clause_punct(gathered), 1'b0, 1'b0);
            gathered = '0;
         end
      end else if (b == TERMINATOR) begin
         emit_word('0, 1'b0, 1'b0, 1'b1);
         str_len = '0;
      end else if (b < CONT_LO) begin
         count_char();
         emit_word(cp_type'(b), is_clause_punct(cp_type'(b)), 1'b0, 1'b0);
      end else if (b < LEAD2_LO || b >= BAD_LO) begin
         count_char();
         emit_word(cp_type'(b), 1'b0, 1'b1, 1'b0);
      end else if (b < LEAD3_LO) begin
         gathered  = cp_type'(b[4:0]);
         cont_left = 2'd1;
      end else if (b < LEAD4_LO) begin
         gathered  = cp_type'(b[3:0]);
         cont_left = 2'd2;
      end else begin
         gathered  = cp_type'(b[2:0]);
         cont_left = 2'd3;
      end
   endtask

   task automatic check_word();
      decoded_type want;
      if (decoded_due.size() == 0) begin
         log_mismatch($sformatf("unexpected word cp=%h end=%b", rsp_code_point,
                                rsp_string_end));
      end else begin
         want = decoded_due.pop_front();
         if (rsp_code_point !== want.cp)
            log_mismatch($sformatf("code_point %h, expected %h", rsp_code_point, want.cp));
         if (rsp_is_clause_end !== want.mark)
            log_mismatch($sformatf("is_clause_end %b, expected %b (cp %h)",
                                   rsp_is_clause_end, want.mark, want.cp));
         if (rsp_bad_lead !== want.bad)
            log_mismatch($sformatf("bad_lead %b, expected %b (cp %h)",
                                   rsp_bad_lead, want.bad, want.cp));
         if (rsp_string_end !== want.fin)
            log_mismatch($sformatf("string_end %b, expected %b", rsp_string_end, want.fin));
         if (rsp_char_count !== want.count)
            log_mismatch($sformatf("char_count %0d, expected %0d", rsp_char_count,
                                   want.count));
      end
   endtask

   task automatic queue_byte(input byte_type v);
      feed_type f;
      f.value = v;
      f.hold  = hold_next;
      hold_next = 1'b0;
      feed.push_back(f);
      bytes_queued++;
   endtask

   task automatic queue_char(input cp_type cp, input int len);
      cp_type     part;
      logic [1:0] top;
      case (len)
         1: queue_byte(byte_type'(cp));
         2: queue_byte({3'b110, cp[10:6]});
         3: queue_byte({4'b1110, cp[15:12]});
         default: queue_byte({5'b11110, cp[20:18]});
      endcase
      for (int k = len - 2; k >= 0; k--) begin
         part = cp >> (6 * k);
         top  = 2'b10;
         if ($urandom_range(0, 3) == 0) top = 2'($urandom_range(0, 3));
         queue_byte({top, part[5:0]});
      end
   endtask

   // one string of random characters plus its terminator, with some noise mixed in
   task automatic queue_string();
      int       n;
      int       kind;
      int       len;
      int       extra;
      cp_type   cp;
      byte_type lead;
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            queue_char(cp_type'($urandom_range(1, 127)), 1);
         end else if (kind < 50) begin
            queue_char(cp_type'($urandom_range(0, 21'h7ff)), 2);
         end else if (kind < 65) begin
            queue_char(cp_type'($urandom_range(0, 21'hffff)), 3);
         end else if (kind < 75) begin
            queue_char(cp_type'($urandom_range(0, 21'h1fffff)), 4);
         end else if (kind < 85) begin
            cp  = PUNCT_MARKS[$urandom_range(0, 11)];
            len = cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
            if ($urandom_range(0, 3) == 0) len = $urandom_range(len, 4);  // overlong form
            queue_char(cp, len);
         end else if (kind < 93) begin
            if ($urandom_range(0, 1) == 0)
               queue_byte(byte_type'($urandom_range(CONT_LO, LEAD2_LO - 1)));
            else queue_byte(byte_type'($urandom_range(BAD_LO, 8'hff)));
         end else begin
            // sequence whose tail bytes are arbitrary, terminators and leads included
            lead  = byte_type'($urandom_range(LEAD2_LO, BAD_LO - 1));
            extra = lead < LEAD3_LO ? 1 : lead < LEAD4_LO ? 2 : 3;
            queue_byte(lead);
            repeat (extra) queue_byte(byte_type'($urandom_range(0, 255)));
         end
      end
      queue_byte(TERMINATOR);
   endtask

   // driver and receiver: change at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (feed.size() == 0 || (feed[0].hold && decoded_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (jitter_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            req_in_byte <= feed[0].value;
            req_valid   <= 1'b1;
            void'(feed.pop_front());
         end
      end

      if (stall_left != 0) stall_left--;
      else if (jitter_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
      rsp_ready <= (stall_left == 0);
   end

   // monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            decode_byte(req_in_byte);
            bytes_taken++;
         end
         if (req_fire || (rsp_valid && rsp_ready)) stuck = 0;
         else stuck++;
         if (stuck == WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int blk;
      int target;

      // extremes, every kind of lead, marks, unchecked continuations
      queue_byte(TERMINATOR);                  // empty string
      queue_byte(8'h7f);
      queue_byte(8'h21);
      queue_byte(8'h80);
      queue_byte(8'hbf);
      queue_byte(8'hf8);
      queue_byte(8'hff);
      queue_byte(8'hc2); queue_byte(8'ha9);
      queue_byte(8'hdf); queue_byte(8'hbf);
      queue_byte(8'he2); queue_byte(8'h80); queue_byte(8'ha6);
      queue_byte(8'hef); queue_byte(8'hbc); queue_byte(8'h8c);
      queue_byte(8'hf7); queue_byte(8'hbf); queue_byte(8'hbf); queue_byte(8'hbf);
      queue_byte(8'hf0); queue_byte(8'h00); queue_byte(8'hc0); queue_byte(8'hff);
      queue_byte(TERMINATOR);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (blk = 0; blk < 4; blk++) begin
         while (feed.size() != 0) @(posedge clock);
         jitter_on = (blk == 0) || ($urandom_range(0, 3) != 0);
         target = bytes_queued + 100;
         while (bytes_queued < target) begin
            if (blk == 2 || $urandom_range(0, 15) == 0) hold_next = 1'b1;
            queue_string();
         end
      end

      // last stretch without idling
      while (feed.size() != 0) @(posedge clock);
      jitter_on = 1'b0;
      hold_next = 1'b1;
      target = bytes_queued + 50;
      while (bytes_queued < target) queue_string();
      queue_byte(8'h41);
      queue_byte(TERMINATOR);

      while (bytes_taken != bytes_queued || decoded_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
